[src/cabac_pkg.sv]
// Shared types, command codes and probability tables of the CABAC encoder core.
`default_nettype none

package cabac_pkg;

	typedef enum logic [2:0] {
		CMD_INIT  = 3'd0,
		CMD_REG   = 3'd1,
		CMD_TERM  = 3'd2,
		CMD_FLUSH = 3'd3,
		CMD_START = 3'd4
	} cmd_t;

	// one output record
	typedef struct packed {
		logic [11:0] value;
		logic [3:0]  length;
		logic [15:0] repeat_count;
		logic        ovf;
	} rec_t;

	localparam logic [8:0] RANGE_RST = 9'd510;
	localparam logic signed [4:0] BL_RST = -5'sd12;
	localparam logic [7:0] BYTE_FF = 8'hff;
	localparam logic [5:0] QP_MAX = 6'd51;
	localparam logic [5:0] QP_RST = 6'd26;

	// rows hold the LPS range for quarter 0..3, quarter 0 in the top byte
	localparam logic [31:0] LPS_TAB [64] = '{
		{8'd128, 8'd176, 8'd208, 8'd240}, {8'd128, 8'd167, 8'd197, 8'd227},
		{8'd128, 8'd158, 8'd187, 8'd216}, {8'd123, 8'd150, 8'd178, 8'd205},
		{8'd116, 8'd142, 8'd169, 8'd195}, {8'd111, 8'd135, 8'd160, 8'd185},
		{8'd105, 8'd128, 8'd152, 8'd175}, {8'd100, 8'd122, 8'd144, 8'd166},
		{8'd95, 8'd116, 8'd137, 8'd158}, {8'd90, 8'd110, 8'd130, 8'd150},
		{8'd85, 8'd104, 8'd123, 8'd142}, {8'd81, 8'd99, 8'd117, 8'd135},
		{8'd77, 8'd94, 8'd111, 8'd128}, {8'd73, 8'd89, 8'd105, 8'd122},
		{8'd69, 8'd85, 8'd100, 8'd116}, {8'd66, 8'd80, 8'd95, 8'd110},
		{8'd62, 8'd76, 8'd90, 8'd104}, {8'd59, 8'd72, 8'd86, 8'd99},
		{8'd56, 8'd69, 8'd81, 8'd94}, {8'd53, 8'd65, 8'd77, 8'd89},
		{8'd51, 8'd62, 8'd73, 8'd85}, {8'd48, 8'd59, 8'd69, 8'd80},
		{8'd46, 8'd56, 8'd66, 8'd76}, {8'd43, 8'd53, 8'd63, 8'd72},
		{8'd41, 8'd50, 8'd59, 8'd69}, {8'd39, 8'd48, 8'd56, 8'd65},
		{8'd37, 8'd45, 8'd54, 8'd62}, {8'd35, 8'd43, 8'd51, 8'd59},
		{8'd33, 8'd41, 8'd48, 8'd56}, {8'd32, 8'd39, 8'd46, 8'd53},
		{8'd30, 8'd37, 8'd43, 8'd50}, {8'd29, 8'd35, 8'd41, 8'd48},
		{8'd27, 8'd33, 8'd39, 8'd45}, {8'd26, 8'd31, 8'd37, 8'd43},
		{8'd24, 8'd30, 8'd35, 8'd41}, {8'd23, 8'd28, 8'd33, 8'd39},
		{8'd22, 8'd27, 8'd32, 8'd37}, {8'd21, 8'd26, 8'd30, 8'd35},
		{8'd20, 8'd24, 8'd29, 8'd33}, {8'd19, 8'd23, 8'd27, 8'd31},
		{8'd18, 8'd22, 8'd26, 8'd30}, {8'd17, 8'd21, 8'd25, 8'd28},
		{8'd16, 8'd20, 8'd23, 8'd27}, {8'd15, 8'd19, 8'd22, 8'd25},
		{8'd14, 8'd18, 8'd21, 8'd24}, {8'd14, 8'd17, 8'd20, 8'd23},
		{8'd13, 8'd16, 8'd19, 8'd22}, {8'd12, 8'd15, 8'd18, 8'd21},
		{8'd12, 8'd14, 8'd17, 8'd20}, {8'd11, 8'd14, 8'd16, 8'd19},
		{8'd11, 8'd13, 8'd15, 8'd18}, {8'd10, 8'd12, 8'd15, 8'd17},
		{8'd10, 8'd12, 8'd14, 8'd16}, {8'd9, 8'd11, 8'd13, 8'd15},
		{8'd9, 8'd11, 8'd12, 8'd14}, {8'd8, 8'd10, 8'd12, 8'd14},
		{8'd8, 8'd9, 8'd11, 8'd13}, {8'd7, 8'd9, 8'd11, 8'd12},
		{8'd7, 8'd9, 8'd10, 8'd12}, {8'd7, 8'd8, 8'd10, 8'd11},
		{8'd6, 8'd8, 8'd9, 8'd11}, {8'd6, 8'd7, 8'd9, 8'd10},
		{8'd6, 8'd7, 8'd8, 8'd9}, {8'd2, 8'd2, 8'd2, 8'd2}
	};

	localparam logic [5:0] LPS_NEXT [64] = '{
		6'd0, 6'd0, 6'd1, 6'd2, 6'd2, 6'd4, 6'd4, 6'd5,
		6'd6, 6'd7, 6'd8, 6'd9, 6'd9, 6'd11, 6'd11, 6'd12,
		6'd13, 6'd13, 6'd15, 6'd15, 6'd16, 6'd16, 6'd18, 6'd18,
		6'd19, 6'd19, 6'd21, 6'd21, 6'd22, 6'd22, 6'd23, 6'd24,
		6'd24, 6'd25, 6'd26, 6'd26, 6'd27, 6'd27, 6'd28, 6'd29,
		6'd29, 6'd30, 6'd30, 6'd30, 6'd31, 6'd32, 6'd32, 6'd33,
		6'd33, 6'd33, 6'd34, 6'd34, 6'd35, 6'd35, 6'd35, 6'd36,
		6'd36, 6'd36, 6'd37, 6'd37, 6'd37, 6'd38, 6'd38, 6'd63
	};

	function automatic logic [7:0] lps_range(input logic [5:0] st, input logic [1:0] q);
		logic [31:0] row;
		row = LPS_TAB[st];
		case (q)
			2'd0:    return row[31:24];
			2'd1:    return row[23:16];
			2'd2:    return row[15:8];
			default: return row[7:0];
		endcase
	endfunction

	// renorm shift after an LPS: 8 minus the index of the top set bit
	function automatic logic [3:0] lps_shift(input logic [7:0] v);
		logic [3:0] s;
		s = 4'd7;
		for (int i = 1; i < 8; i++)
			if (v[i]) s = 4'(8 - i);
		return s;
	endfunction

	// {state, mps} from init value and slice QP
	function automatic logic [6:0] derive_state(input logic [5:0] qp, input logic [7:0] iv);
		logic [5:0]         q;
		logic signed [7:0]  slope;
		logic signed [7:0]  offs;
		logic signed [13:0] prod;
		logic signed [13:0] s;
		logic [6:0]         sc;
		q     = (qp > QP_MAX) ? QP_MAX : qp;
		slope = 8'(signed'({1'b0, iv[7:4]}) * 5) - 8'sd45;
		offs  = signed'({1'b0, iv[3:0], 3'b000}) - 8'sd16;
		prod  = 14'(slope) * signed'({8'b0, q});
		s     = (prod >>> 4) + 14'(offs);
		if (s < 14'sd1) sc = 7'd1;
		else if (s > 14'sd126) sc = 7'd126;
		else sc = s[6:0];
		if (sc >= 7'd64) return {sc[5:0], 1'b1};
		return {6'(7'd63 - sc), 1'b0};
	endfunction

endpackage

`default_nettype wire

[src/cabac_binary_arithmetic_encoder_core.sv]
// Top level of the CABAC binary arithmetic encoder core.
// Usage:
//  - s_* channel carries one command word per handshake (init context,
//    regular bin, terminate bin, flush, start). cfg_* writes slice_qp; write
//    it only while the core is idle.
//  - m_* channel returns bitstream records: bits to append, their count, a
//    repeat count for runs of 0xff bytes (0x00 after a carry), a saturation
//    flag. m_tlast marks the last record caused by one command.
//  - Each accepted word sits in the _s1 register while its context is read
//    from the context RAM (registered read, with a bypass of the latest
//    write), then engine state updates and up to six records load into the
//    output slot buffer.
//  - Records load when the word leaves _s1; m_tvalid is high from then on.
//  - Throughput: one command per cycle while commands produce no records.
//    A command that produces records waits in _s1 until the previous
//    command's records have drained, one record per cycle while m_tready is
//    high; the slot buffer is the limit.
//  - Reset clears engine state, slice_qp (26) and the buffers; the context
//    RAM is not cleared and must be initialized before use.
//  - When m_tready is low records hold; s_tready drops once a command with
//    records is waiting behind them.
`default_nettype none

module cabac_binary_arithmetic_encoder_core #(
	parameter int NUM_CONTEXTS   = 256,
	parameter int RUN_COUNT_BITS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [23:0] s_tdata,   // context_index[7:0], bin_value[8], init_value[16:9]
	input  wire  [2:0]  s_tuser,   // command[2:0]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [31:0] m_tdata,   // out_value[11:0], out_length[15:12], repeat_count[31:16]
	output logic [0:0]  m_tuser,   // run_overflow[0]
	output logic        m_tlast,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [5:0]  cfg_data
);
	import cabac_pkg::*;

	localparam int AW = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
	localparam int RC = RUN_COUNT_BITS;

	typedef struct packed {
		logic [31:0]       low;
		logic [8:0]        rng;
		logic signed [4:0] bl;
		logic [RC-1:0]     cnt;
		logic [7:0]        bb;
		logic              sat;
	} eng_t;

	typedef struct packed {
		logic          vld;
		logic [AW-1:0] addr;
		logic [6:0]    data;
	} fwd_t;

	// run record: repeat count is cnt - 1, clamped to 16 bits
	function automatic rec_t run_rec(input logic [7:0] b, input logic [RC-1:0] c,
			input logic s);
		rec_t          r;
		logic [RC-1:0] rep;
		logic          clamp;
		rep   = c - RC'(1);
		clamp = (33'(rep) > 33'd65535);
		r.value        = {4'd0, b};
		r.length       = 4'd8;
		r.repeat_count = clamp ? 16'hffff : 16'(rep);
		r.ovf          = s | clamp;
		return r;
	endfunction

	function automatic rec_t byte_rec(input logic [7:0] b);
		rec_t r;
		r.value        = {4'd0, b};
		r.length       = 4'd8;
		r.repeat_count = 16'd1;
		r.ovf          = 1'b0;
		return r;
	endfunction

	// byte output with carry hold-back; bits_left known non-negative
	function automatic void wr_out(input eng_t e, output eng_t eo, output rec_t r0,
			output rec_t r1, output logic v0, output logic v1);
		logic [4:0]  sh;
		logic [4:0]  msh;
		logic [31:0] lead;
		logic [7:0]  carry;
		sh    = 5'(5'd13 + e.bl);
		msh   = 5'(5'd19 - e.bl);
		lead  = e.low >> sh;
		carry = lead[15:8];
		eo     = e;
		eo.bl  = e.bl - 5'sd8;
		eo.low = e.low & (32'hffffffff >> msh);
		v0 = 1'b0;
		v1 = 1'b0;
		r0 = byte_rec(8'(e.bb + carry));
		r1 = run_rec(8'(BYTE_FF + carry), e.cnt, e.sat);
		if (lead == 32'(BYTE_FF)) begin
			if (e.cnt == {RC{1'b1}}) eo.sat = 1'b1;
			else eo.cnt = e.cnt + RC'(1);
		end else begin
			v0     = (e.cnt != '0);
			v1     = (e.cnt > RC'(1));
			eo.cnt = RC'(1);
			eo.bb  = lead[7:0];
			eo.sat = 1'b0;
		end
	endfunction

	// input stage
	logic            vld_s1;
	cmd_t            cmd_s1;
	logic [7:0]      idx_s1;
	logic            bin_s1;
	logic [7:0]      iv_s1;
	logic [6:0]      rd_s1;
	logic [5:0]      qp_q;
	eng_t            eng_q;
	fwd_t            fwd_q;
	logic [6:0]      ctx_mem [NUM_CONTEXTS];

	// output slot buffer
	rec_t            res_q [6];
	logic [2:0]      res_cnt_q;
	logic [2:0]      rd_ptr_q;

	// next-state results
	eng_t            eng_d;
	rec_t            res_c [6];
	logic [2:0]      n_c;
	logic            mem_we;
	logic [6:0]      mem_wd;
	logic            in_rng_s1;
	logic [AW-1:0]   addr_s1;
	logic            s_fire;
	logic            s1_fire;
	logic            buf_free;
	logic            m_fire;

	assign s_fire    = s_tvalid & s_tready;
	assign m_fire    = m_tvalid & m_tready;
	assign in_rng_s1 = (11'(idx_s1) < 11'(NUM_CONTEXTS));
	assign addr_s1   = AW'(idx_s1);
	assign buf_free  = (rd_ptr_q == res_cnt_q) ||
	                   (m_fire && (rd_ptr_q == 3'(res_cnt_q - 3'd1)));
	assign s1_fire   = vld_s1 && ((n_c == 3'd0) || buf_free);
	assign s_tready  = !vld_s1 || s1_fire;
	assign cfg_ready = 1'b1;

	always_comb begin
		logic [6:0]  ms;
		logic [5:0]  st;
		logic        mps;
		logic [7:0]  lps;
		logic [8:0]  r;
		logic [31:0] lo;
		logic [3:0]  nb;
		logic [5:0]  nst;
		logic        lps_path;
		eng_t        e1;
		eng_t        e2;
		rec_t        w0;
		rec_t        w1;
		logic        wv0;
		logic        wv1;
		logic [4:0]  fsh;
		logic signed [5:0] flen;
		logic [3:0]  len;
		logic [11:0] mask;
		rec_t        fr;

		eng_d  = eng_q;
		n_c    = 3'd0;
		mem_we = 1'b0;
		mem_wd = derive_state(qp_q, iv_s1);
		for (int i = 0; i < 6; i++) res_c[i] = byte_rec(8'd0);
		fsh  = 5'd0;
		flen = 6'sd0;
		len  = 4'd1;
		mask = 12'd0;
		fr   = byte_rec(8'd0);

		// context read with bypass of the latest write
		ms = (fwd_q.vld && fwd_q.addr == addr_s1) ? fwd_q.data : rd_s1;
		if (!in_rng_s1) ms = 7'd0;
		st  = ms[6:1];
		mps = ms[0];
		lps = lps_range(st, eng_q.rng[7:6]);
		r   = eng_q.rng - 9'(lps);
		lo  = eng_q.low;
		lps_path = (bin_s1 != mps);
		if (lps_path) begin
			nb  = (st == 6'd63) ? 4'd6 : lps_shift(lps);
			lo  = eng_q.low + 32'(r);
			r   = 9'(lps);
			nst = LPS_NEXT[st];
		end else begin
			nb  = (r < 9'd256) ? 4'd1 : 4'd0;
			nst = (st < 6'd62) ? 6'(st + 6'd1) : st;
		end

		e1  = eng_q;
		wv0 = 1'b0;
		wv1 = 1'b0;
		w0  = byte_rec(8'd0);
		w1  = byte_rec(8'd0);
		e2  = eng_q;

		unique case (cmd_s1)
			CMD_INIT: begin
				mem_we = in_rng_s1;
			end
			CMD_REG: begin
				e1.low = lo << nb;
				e1.rng = 9'(r << nb);
				e1.bl  = eng_q.bl + signed'({1'b0, nb});
				mem_we = in_rng_s1;
				mem_wd = {nst, (lps_path && st == 6'd0) ? ~mps : mps};
				e2 = e1;
				if (!e1.bl[4]) wr_out(e1, e2, w0, w1, wv0, wv1);
				eng_d = e2;
				if (wv0) begin res_c[n_c] = w0; n_c = 3'(n_c + 3'd1); end
				if (wv1) begin res_c[n_c] = w1; n_c = 3'(n_c + 3'd1); end
			end
			CMD_TERM, CMD_FLUSH: begin
				e1.rng = eng_q.rng - 9'd2;
				if (bin_s1 || cmd_s1 == CMD_FLUSH) begin
					e1.low = (eng_q.low + 32'(e1.rng)) << 7;
					e1.rng = 9'd256;
					e1.bl  = eng_q.bl + 5'sd7;
				end else if (!e1.rng[8]) begin
					e1.low = eng_q.low << 1;
					e1.rng = 9'(e1.rng << 1);
					e1.bl  = eng_q.bl + 5'sd1;
				end
				e2 = e1;
				if (!e1.bl[4]) wr_out(e1, e2, w0, w1, wv0, wv1);
				eng_d = e2;
				if (wv0) begin res_c[n_c] = w0; n_c = 3'(n_c + 3'd1); end
				if (wv1) begin res_c[n_c] = w1; n_c = 3'(n_c + 3'd1); end
				if (cmd_s1 == CMD_FLUSH) begin
					// finish: resolve the last carry, then the tail bits and the stop bit, then reset the engine
					fsh  = 5'(5'd21 + e2.bl);
					flen = 6'sd13 + 6'(e2.bl);
					if ((e2.low >> fsh) != 32'd0) begin
						res_c[n_c] = byte_rec(8'(e2.bb + 8'd1));
						n_c = 3'(n_c + 3'd1);
						if (e2.cnt > RC'(1)) begin
							res_c[n_c] = run_rec(8'd0, e2.cnt, e2.sat);
							n_c = 3'(n_c + 3'd1);
						end
						e2.low = e2.low - (32'd1 << fsh);
					end else begin
						if (e2.cnt != '0) begin
							res_c[n_c] = byte_rec(e2.bb);
							n_c = 3'(n_c + 3'd1);
						end
						if (e2.cnt > RC'(1)) begin
							res_c[n_c] = run_rec(BYTE_FF, e2.cnt, e2.sat);
							n_c = 3'(n_c + 3'd1);
						end
					end
					if (flen < 6'sd1) len = 4'd1;
					else if (flen > 6'sd12) len = 4'd12;
					else len = flen[3:0];
					mask = 12'((13'd1 << len) - 13'd1);
					fr.value        = 12'(e2.low >> 8) & mask;
					fr.length       = len;
					fr.repeat_count = 16'd1;
					fr.ovf          = 1'b0;
					res_c[n_c] = fr;
					n_c = 3'(n_c + 3'd1);
					fr.value  = 12'd1;
					fr.length = 4'd1;
					res_c[n_c] = fr;
					n_c = 3'(n_c + 3'd1);
					eng_d.low = '0;
					eng_d.rng = RANGE_RST;
					eng_d.bl  = BL_RST;
					eng_d.cnt = '0;
					eng_d.bb  = BYTE_FF;
					eng_d.sat = 1'b0;
				end
			end
			CMD_START: begin
				eng_d.low = '0;
				eng_d.rng = RANGE_RST;
				eng_d.bl  = BL_RST;
				eng_d.cnt = '0;
				eng_d.bb  = BYTE_FF;
				eng_d.sat = 1'b0;
			end
			default: begin
			end
		endcase
	end

	// context RAM: registered read at acceptance, write when the item retires
	always_ff @(posedge clk) begin
		if (s_fire) rd_s1 <= ctx_mem[AW'(s_tdata[7:0])];
		if (s1_fire && mem_we) ctx_mem[addr_s1] <= mem_wd;
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			cmd_s1 <= cmd_t'(s_tuser);
			idx_s1 <= s_tdata[7:0];
			bin_s1 <= s_tdata[8];
			iv_s1  <= s_tdata[16:9];
		end
		if (s1_fire && n_c != 3'd0) begin
			for (int i = 0; i < 6; i++) res_q[i] <= res_c[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			qp_q      <= QP_RST;
			eng_q.low <= '0;
			eng_q.rng <= RANGE_RST;
			eng_q.bl  <= BL_RST;
			eng_q.cnt <= '0;
			eng_q.bb  <= BYTE_FF;
			eng_q.sat <= 1'b0;
			fwd_q     <= '0;
			res_cnt_q <= 3'd0;
			rd_ptr_q  <= 3'd0;
		end else begin
			if (cfg_valid && cfg_ready) qp_q <= cfg_data;
			if (s_fire) vld_s1 <= 1'b1;
			else if (s1_fire) vld_s1 <= 1'b0;
			if (s1_fire) begin
				eng_q <= eng_d;
				if (mem_we) begin
					fwd_q.vld  <= 1'b1;
					fwd_q.addr <= addr_s1;
					fwd_q.data <= mem_wd;
				end
			end
			if (s1_fire && n_c != 3'd0) begin
				res_cnt_q <= n_c;
				rd_ptr_q  <= 3'd0;
			end else if (m_fire) begin
				rd_ptr_q <= 3'(rd_ptr_q + 3'd1);
			end
		end
	end

	assign m_tvalid = (rd_ptr_q != res_cnt_q);
	assign m_tdata  = {res_q[rd_ptr_q].repeat_count, res_q[rd_ptr_q].length,
	                   res_q[rd_ptr_q].value};
	assign m_tuser  = res_q[rd_ptr_q].ovf;
	assign m_tlast  = (rd_ptr_q == 3'(res_cnt_q - 3'd1));

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		res_cnt_q <= 3'd6 && rd_ptr_q <= res_cnt_q)
		else $error("slot buffer count out of range");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && n_c != 3'd0) |-> buf_free)
		else $error("records loaded over undrained slots");
	a_last_then_new: assert property (@(posedge clk) disable iff (!arst_n)
		(m_fire && m_tlast) |=> (!m_tvalid || rd_ptr_q == 3'd0))
		else $error("record stream continued past last");
	a_bits_left_neg: assert property (@(posedge clk) disable iff (!arst_n)
		eng_q.bl[4])
		else $error("bits_left non-negative between commands");

endmodule

`default_nettype wire

[sim/cabac_encoder_checker.sv]
// Watches the command, record and qp channels of the CABAC core, predicts and compares.
`timescale 1ns / 100ps
`default_nettype none

module cabac_encoder_checker (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	input  wire         s_tready,
	input  wire  [23:0] s_tdata,
	input  wire  [2:0]  s_tuser,
	input  wire         m_tvalid,
	input  wire         m_tready,
	input  wire  [31:0] m_tdata,
	input  wire  [0:0]  m_tuser,
	input  wire         m_tlast,
	input  wire         cfg_valid,
	input  wire         cfg_ready,
	input  wire  [5:0]  cfg_data,
	output int          mismatches,
	output int          records_owed,
	output int          words_in,
	output int          records_seen
);
	import cabac_pkg::*;

	typedef struct {
		logic [11:0] bits;
		logic [3:0]  nbits;
		logic [15:0] reps;
		logic        ovf;
		logic        last;
	} bitrec_t;

	bitrec_t     owed_q[$];
	logic [6:0]  ctx_mem [256];
	logic [31:0] low;
	logic [8:0]  rng;
	int          bl;
	int unsigned held_n;
	logic [7:0]  held_byte;
	bit          held_sat;
	logic [5:0]  qp;
	int          n_emit;

	assign records_owed = owed_q.size();

	task automatic put(input logic [11:0] v, input int len, input int unsigned rep,
			input logic ovf);
		bitrec_t r;
		if (n_emit >= 6) return;
		r.bits  = v;
		r.nbits = 4'(len);
		r.reps  = (rep > 65535) ? 16'hffff : 16'(rep);
		r.ovf   = (rep > 65535) ? 1'b1 : ovf;
		r.last  = 1'b0;
		owed_q.push_back(r);
		n_emit++;
	endtask

	task automatic restart();
		low       = '0;
		rng       = RANGE_RST;
		bl        = -12;
		held_n    = 0;
		held_byte = BYTE_FF;
		held_sat  = 0;
	endtask

	// byte leaves the low register; 0xff bytes are held back for carry
	task automatic push_byte();
		logic [31:0] lead;
		int          msh;
		lead = low >> ((13 + bl) & 31);
		msh  = (19 - bl) & 31;
		bl  -= 8;
		low &= 32'hffff_ffff >> msh;
		if (lead == 32'hff) begin
			if (held_n >= 65535) held_sat = 1;
			else held_n++;
			return;
		end
		if (held_n > 0) begin
			put(12'((held_byte + lead[8]) & 8'hff), 8, 1, 0);
			if (held_n > 1)
				put(12'(8'(8'hff + lead[8])), 8, held_n - 1, held_sat);
		end
		held_n    = 1;
		held_byte = lead[7:0];
		held_sat  = 0;
	endtask

	function automatic logic [6:0] init_state(input logic [5:0] q, input logic [7:0] iv);
		int slope, offs, s, qq;
		qq    = (q > QP_MAX) ? QP_MAX : q;
		slope = int'(iv[7:4]) * 5 - 45;
		offs  = int'(iv[3:0]) * 8 - 16;
		s     = ((slope * qq) >>> 4) + offs;   // arithmetic shift floors
		if (s < 1) s = 1;
		if (s > 126) s = 126;
		if (s >= 64) return {6'(s - 64), 1'b1};
		return {6'(63 - s), 1'b0};
	endfunction

	task automatic code_bin(input logic [7:0] idx, input logic b);
		logic [5:0]  st, nst;
		logic        mps;
		logic [7:0]  lps;
		logic [31:0] row;
		logic [8:0]  r;
		int          nb, msb;
		st   = ctx_mem[idx][6:1];
		mps  = ctx_mem[idx][0];
		row  = LPS_TAB[st];
		lps  = row[31 - 8 * rng[7:6] -: 8];
		r    = rng - 9'(lps);
		nb   = (r < 9'd256) ? 1 : 0;
		if (b != mps) begin
			msb = 0;
			for (int i = 1; i < 8; i++)
				if (lps[i]) msb = i;
			nb  = (st == 6'd63) ? 6 : 8 - msb;
			low = low + 32'(r);
			r   = 9'(lps);
			if (st == 0) mps = ~mps;
			nst = LPS_NEXT[st];
		end else begin
			nst = (st < 62) ? st + 6'd1 : st;
		end
		low          = low << nb;
		rng          = 9'(r << nb);
		bl          += nb;
		ctx_mem[idx] = {nst, mps};
		if (bl >= 0) push_byte();
	endtask

	task automatic code_term(input logic b);
		rng = rng - 9'd2;
		if (b) begin
			low = (low + 32'(rng)) << 7;
			rng = 9'd256;
			bl += 7;
		end else if (rng >= 9'd256) begin
			return;
		end else begin
			low = low << 1;
			rng = rng << 1;
			bl += 1;
		end
		if (bl >= 0) push_byte();
	endtask

	task automatic close_code();
		int sh, len;
		sh  = (21 + bl) & 31;
		len = 13 + bl;
		if ((low >> sh) != 0) begin
			put(12'(8'(held_byte + 8'd1)), 8, 1, 0);
			if (held_n > 1) put(12'd0, 8, held_n - 1, held_sat);
			low = low - (32'd1 << sh);
		end else begin
			if (held_n > 0) put(12'(held_byte), 8, 1, 0);
			if (held_n > 1) put(12'hff, 8, held_n - 1, held_sat);
		end
		if (len < 1) len = 1;
		if (len > 12) len = 12;
		put(12'((low >> 8) & ((32'd1 << len) - 1)), len, 1, 0);
	endtask

	task automatic run_command(input logic [2:0] cmd, input logic [23:0] d);
		n_emit = 0;
		case (cmd)
			CMD_INIT:  ctx_mem[d[7:0]] = init_state(qp, d[16:9]);
			CMD_REG:   code_bin(d[7:0], d[8]);
			CMD_TERM:  code_term(d[8]);
			CMD_FLUSH: begin
				code_term(1'b1);
				close_code();
				put(12'd1, 1, 1, 0);   // stop bit
				restart();
			end
			CMD_START: restart();
			default: ;
		endcase
		if (n_emit > 0) owed_q[$].last = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_q.delete();
			foreach (ctx_mem[i]) ctx_mem[i] = '0;
			qp           = QP_RST;
			restart();
			mismatches   = 0;
			words_in     = 0;
			records_seen = 0;
		end else begin
			// output first: a record never answers the word taken on the same edge
			if (m_tvalid && m_tready) begin
				records_seen++;
				if (owed_q.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected record value=%h len=%0d", $time,
						m_tdata[11:0], m_tdata[15:12]);
				end else begin
					bitrec_t w;
					w = owed_q.pop_front();
					if (m_tdata[11:0] !== w.bits || m_tdata[15:12] !== w.nbits ||
							m_tdata[31:16] !== w.reps || m_tuser[0] !== w.ovf ||
							m_tlast !== w.last) begin
						mismatches++;
						$display("%0t: record mismatch expected v=%h l=%0d rep=%0d ovf=%b last=%b",
							$time, w.bits, w.nbits, w.reps, w.ovf, w.last);
						$display("%0t:                  actual   v=%h l=%0d rep=%0d ovf=%b last=%b",
							$time, m_tdata[11:0], m_tdata[15:12], m_tdata[31:16],
							m_tuser[0], m_tlast);
					end
				end
			end
			if (cfg_valid && cfg_ready) qp = cfg_data;
			if (s_tvalid && s_tready) begin
				words_in++;
				run_command(s_tuser, s_tdata);
			end
		end
	end

endmodule

`default_nettype wire

[sim/cabac_binary_arithmetic_encoder_core_tb.sv]
// Stimulus and verdict for the CABAC encoder core: directed commands, random slices, qp sweeps.
`timescale 1ns / 100ps
`default_nettype none

module cabac_binary_arithmetic_encoder_core_tb;
	import cabac_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam logic [2:0] CMD_RSV5 = 3'd5;
	localparam logic [2:0] CMD_RSV6 = 3'd6;
	localparam logic [2:0] CMD_RSV7 = 3'd7;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;   // context_index[7:0], bin_value[8], init_value[16:9]
	logic [2:0]  s_tuser = '0;   // command[2:0]
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [31:0] m_tdata;        // out_value[11:0], out_length[15:12], repeat_count[31:16]
	logic [0:0]  m_tuser;        // run_overflow[0]
	logic        m_tlast;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [5:0]  cfg_data = '0;

	int mismatches, records_owed, words_in, records_seen;
	int cycles = 0;
	bit hold_req = 0;      // asks the receiver for one long hold-off
	bit ctx_ready [256];   // contexts that have been initialized
	int ctx_list[$];

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	cabac_binary_arithmetic_encoder_core uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	cabac_encoder_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.mismatches(mismatches), .records_owed(records_owed),
		.words_in(words_in), .records_seen(records_seen)
	);

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// short random gap length, now and then a long one
	function automatic int gap_len();
		int p;
		p = $urandom_range(99);
		if (p < 55) return 0;
		if (p < 92) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// record side: random stalls, plus one long hold while commands keep coming
	initial begin
		int hold;
		bit held_once;
		held_once = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && !held_once) begin
				held_once = 1;
				hold = 300;
			end
			if (hold > 0) begin
				hold--;
				m_tready <= 0;
			end else begin
				hold = gap_len();
				m_tready <= (hold == 0);
				if (hold > 0) hold--;
			end
		end
	end

	// one command word; valid stays high between back-to-back words
	task automatic send(input logic [2:0] cmd, input logic [7:0] idx, input logic b,
			input logic [7:0] iv, input bit no_gap = 0);
		int g;
		g = no_gap ? 0 : gap_len();
		if (g > 0) begin
			s_tvalid <= 0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser  <= cmd;
		s_tdata  <= {7'b0, iv, b, idx};
		do @(posedge clk); while (!s_tready);
		if (cmd == CMD_INIT && !ctx_ready[idx]) begin
			ctx_ready[idx] = 1;
			ctx_list.push_back(idx);
		end
	endtask

	// drain everything owed, let the pipe settle
	task automatic drain();
		s_tvalid <= 0;
		@(posedge clk);
		while (records_owed != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic set_qp(input logic [5:0] q);
		drain();
		cfg_valid <= 1;
		cfg_data  <= q;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
	endtask

	function automatic logic [7:0] any_ctx();
		return 8'(ctx_list[$urandom_range(ctx_list.size() - 1)]);
	endfunction

	initial begin
		logic [2:0] rsv [3];
		int p;
		rsv = '{CMD_RSV5, CMD_RSV6, CMD_RSV7};
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: init extremes at the reset qp, then qp 0 and the clipped top
		send(CMD_INIT, 8'd0, 0, 8'h00);
		send(CMD_INIT, 8'd255, 1, 8'hff);
		send(CMD_INIT, 8'd85, 0, 8'h9a);
		set_qp(6'd0);
		send(CMD_INIT, 8'd170, 1, 8'h0f);
		set_qp(6'd63);   // above 51, clipped by init
		send(CMD_INIT, 8'd1, 0, 8'hf0);
		send(CMD_INIT, 8'd2, 0, 8'h5f);
		set_qp(6'd51);
		send(CMD_INIT, 8'd3, 1, 8'h10);
		// MPS and LPS on edge states, terminate both ways, reserved codes
		for (int i = 0; i < 6; i++) send(CMD_REG, 8'd0, 1'(i & 1), 8'h00);
		send(CMD_REG, 8'd255, 0, 8'h00);
		send(CMD_REG, 8'd1, 1, 8'h00);
		send(CMD_TERM, 8'd0, 0, 8'h00);
		send(CMD_TERM, 8'd0, 1, 8'h00);
		send(CMD_RSV5, 8'hff, 1, 8'hff);
		send(CMD_RSV6, 8'd0, 0, 8'h00);
		send(CMD_RSV7, 8'd0, 1, 8'h00);
		send(CMD_FLUSH, 8'd0, 0, 8'h00);
		send(CMD_START, 8'd0, 0, 8'h00);
		send(CMD_FLUSH, 8'd0, 0, 8'h00);   // flush of an empty engine

		// random slices, each under its own qp
		for (int ph = 0; ph < 5; ph++) begin
			set_qp(ph == 4 ? 6'd26 : 6'($urandom_range(63)));
			repeat (8) send(CMD_INIT, 8'($urandom), 1'($urandom), 8'($urandom));
			for (int n = 0; n < 30; n++) begin
				if (ph == 2 && n == 5) hold_req = 1;
				p = $urandom_range(99);
				if (p < 72)
					send(CMD_REG, any_ctx(), 1'($urandom), 8'($urandom), hold_req && n < 25);
				else if (p < 80) send(CMD_INIT, 8'($urandom), 1'($urandom), 8'($urandom));
				else if (p < 88) send(CMD_TERM, 8'($urandom), 1'($urandom_range(9) == 0),
						8'($urandom));
				else if (p < 93) send(CMD_FLUSH, 8'($urandom), 1'($urandom), 8'($urandom));
				else if (p < 96) send(CMD_START, 8'($urandom), 1'($urandom), 8'($urandom));
				else send(rsv[$urandom_range(2)], 8'($urandom), 1'($urandom), 8'($urandom));
			end
			send(CMD_FLUSH, 8'd0, 0, 8'h00);
		end

		drain();
		$display("Run took %0d command words and checked %0d records over several qp settings,",
			words_in, records_seen);
		$display("with random stalls on both sides and one long output hold-off.");
		if (mismatches == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire

[filelist.f]
src/cabac_pkg.sv
src/cabac_binary_arithmetic_encoder_core.sv
sim/cabac_encoder_checker.sv
sim/cabac_binary_arithmetic_encoder_core_tb.sv
